// ===== hw/rtl/mebr_pkg.sv =====
// package for the midi event beat release buffer
// holds sizes, item and result structs and the release queue entry
// depends on nothing
`timescale 1ns / 1ps

package mebr_pkg;

  localparam int unsigned EVENT_DEPTH  = 64;
  localparam int unsigned RING_DEPTH   = 2 * EVENT_DEPTH;
  localparam int unsigned RING_AW      = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W        = $clog2(EVENT_DEPTH + 1);
  localparam int unsigned PERIOD_W     = 24;
  localparam int unsigned EVENT_W      = 24;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(88200);
  localparam logic [PERIOD_W-1:0] PERIOD_FLOOR = PERIOD_W'(64);
  localparam logic [7:0]          TRANSPORT_MASK = 8'hFE;

  localparam logic ACT_EVENT = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] status_byte;
    logic [7:0] data_one;
    logic [7:0] data_two;
    logic [7:0] transport_state;
  } item_t;

  typedef struct packed {
    logic [7:0] out_status;
    logic [7:0] out_data_one;
    logic [7:0] out_data_two;
    logic       last;
  } result_t;

  // one release burst handed from front to the release queue
  typedef struct packed {
    logic             push;
    logic [CNT_W-1:0] count;
  } release_t;

endpackage

// ===== hw/rtl/midi_event_beat_release_buffer.sv =====
// top level of the midi event beat release buffer
// uses mebr_pkg, mebr_front, mebr_queue, mebr_back and mebr_ram
`timescale 1ns / 1ps

// An item is taken whenever busy is low. A release burst of n stored events
// appears on result_o as n beats in consecutive cycles, marked by
// result_valid_o, with the final one flagged by last. When the back part is
// idle, the burst is written into the release queue, popped into the back
// part's remaining count, and its first event is read from the ring into the
// ram's read register, which drives the ports; it is taken at the edge after
// that. Events sit in a 128-entry ring, so up to two bursts may wait in the
// release queue while new events are stored. busy rises only when two bursts
// are pending or the ring holds 128 unread events. The back part pops each
// burst before reading its beats. Results cannot be held off by the receiver.
module midi_event_beat_release_buffer import mebr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  item_t               item_i,
  output logic                result_valid_o,
  output result_t             result_o,
  input  logic                cfg_we_i,
  input  logic [PERIOD_W-1:0] cfg_data_i
);

  logic               accept;
  logic               we;
  logic [RING_AW-1:0] waddr, raddr;
  logic [EVENT_W-1:0] wdata, rdata;
  logic [RING_AW:0]   wr_ptr, rd_ptr, occupancy;
  release_t           rel;
  logic               q_full, q_empty, pop, re, last;
  logic [CNT_W-1:0]   q_count;

  assign occupancy = wr_ptr - rd_ptr;
  assign busy      = q_full || (occupancy == (RING_AW+1)'(RING_DEPTH));
  assign accept    = start && !busy;

  mebr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .wr_ptr_o   (wr_ptr),
    .rel_o      (rel)
  );

  mebr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rel_i   (rel),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  mebr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_count_i (q_count),
    .pop_o     (pop),
    .re_o      (re),
    .raddr_o   (raddr),
    .rd_ptr_o  (rd_ptr),
    .valid_o   (result_valid_o),
    .last_o    (last)
  );

  mebr_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign result_o.out_status   = rdata[23:16];
  assign result_o.out_data_one = rdata[15:8];
  assign result_o.out_data_two = rdata[7:0];
  assign result_o.last         = last;

endmodule

// ===== hw/rtl/mebr_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module mebr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mebr_front.sv =====
// front part: takes items, appends events to the ring, tracks transport and countdown
// issues release bursts to the queue; uses mebr_pkg
`timescale 1ns / 1ps

module mebr_front import mebr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  item_t               item_i,
  input  logic                cfg_we_i,
  input  logic [PERIOD_W-1:0] cfg_data_i,
  output logic                we_o,
  output logic [RING_AW-1:0]  waddr_o,
  output logic [EVENT_W-1:0]  wdata_o,
  output logic [RING_AW:0]    wr_ptr_o,
  output release_t            rel_o
);

  logic [PERIOD_W-1:0] period_q, period_d;
  logic [PERIOD_W-1:0] countdown_q, countdown_d;
  logic [7:0]          prev_q, prev_d;
  logic                playing_q, playing_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [RING_AW:0]    wr_ptr_q, wr_ptr_d;
  logic [7:0]          state_s;
  logic [PERIOD_W-1:0] cd_s;
  logic [PERIOD_W-1:0] period_eff;

  assign state_s    = item_i.transport_state & TRANSPORT_MASK;
  assign period_eff = (period_q < PERIOD_FLOOR) ? PERIOD_FLOOR : period_q;

  always_comb begin
    period_d    = cfg_we_i ? cfg_data_i : period_q;
    countdown_d = countdown_q;
    prev_d      = prev_q;
    playing_d   = playing_q;
    cnt_d       = cnt_q;
    wr_ptr_d    = wr_ptr_q;
    we_o        = 1'b0;
    rel_o.push  = 1'b0;
    rel_o.count = cnt_q;
    cd_s        = countdown_q;
    if (accept_i) begin
      if (item_i.action == ACT_EVENT) begin
        if (cnt_q < CNT_W'(EVENT_DEPTH)) begin
          we_o     = 1'b1;
          cnt_d    = cnt_q + CNT_W'(1);
          wr_ptr_d = wr_ptr_q + (RING_AW+1)'(1);
        end
      end else begin
        if (state_s != prev_q) begin
          prev_d    = state_s;
          playing_d = state_s[1];
          if (state_s[1]) begin
            cd_s = '0;
          end
        end
        if (playing_d) begin
          if (cd_s == '0) begin
            rel_o.push  = (cnt_q != '0);
            cnt_d       = '0;
            countdown_d = period_eff - PERIOD_W'(1);
          end else begin
            countdown_d = cd_s - PERIOD_W'(1);
          end
        end else begin
          countdown_d = cd_s;
        end
      end
    end
  end

  assign waddr_o  = wr_ptr_q[RING_AW-1:0];
  assign wdata_o  = {item_i.status_byte, item_i.data_one, item_i.data_two};
  assign wr_ptr_o = wr_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RESET;
      countdown_q <= '0;
      prev_q      <= '0;
      playing_q   <= 1'b0;
      cnt_q       <= '0;
      wr_ptr_q    <= '0;
    end else begin
      period_q    <= period_d;
      countdown_q <= countdown_d;
      prev_q      <= prev_d;
      playing_q   <= playing_d;
      cnt_q       <= cnt_d;
      wr_ptr_q    <= wr_ptr_d;
    end
  end

endmodule

// ===== hw/rtl/mebr_queue.sv =====
// short queue of pending release bursts between front and back
// uses mebr_pkg
`timescale 1ns / 1ps

module mebr_queue import mebr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  release_t         rel_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output logic [CNT_W-1:0] count_o
);

  logic [CNT_W-1:0]    slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [QUEUE_AW:0]   fill_q, fill_d;
  logic                do_push, do_pop;

  assign full_o  = (fill_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign count_o = slot_q[rp_q];
  assign do_push = rel_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wp_d   = do_push ? wp_q + QUEUE_AW'(1) : wp_q;
    rp_d   = do_pop ? rp_q + QUEUE_AW'(1) : rp_q;
    fill_d = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + (QUEUE_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - (QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= rel_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fill_q <= '0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      fill_q <= fill_d;
    end
  end

endmodule

// ===== hw/rtl/mebr_back.sv =====
// back part: drains one release burst at a time from the ring, one beat per cycle
// uses mebr_pkg
`timescale 1ns / 1ps

module mebr_back import mebr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  logic [CNT_W-1:0] q_count_i,
  output logic             pop_o,
  output logic             re_o,
  output logic [RING_AW-1:0] raddr_o,
  output logic [RING_AW:0] rd_ptr_o,
  output logic             valid_o,
  output logic             last_o
);

  logic [CNT_W-1:0] rem_q, rem_d;
  logic [RING_AW:0] rd_ptr_q, rd_ptr_d;
  logic             valid_q, last_q;

  always_comb begin
    pop_o    = 1'b0;
    re_o     = 1'b0;
    rem_d    = rem_q;
    rd_ptr_d = rd_ptr_q;
    if (rem_q != '0) begin
      re_o     = 1'b1;
      rem_d    = rem_q - CNT_W'(1);
      rd_ptr_d = rd_ptr_q + (RING_AW+1)'(1);
    end else if (!q_empty_i) begin
      pop_o = 1'b1;
      rem_d = q_count_i;
    end
  end

  assign raddr_o  = rd_ptr_q[RING_AW-1:0];
  assign rd_ptr_o = rd_ptr_q;
  assign valid_o  = valid_q;
  assign last_o   = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q    <= '0;
      rd_ptr_q <= '0;
      valid_q  <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      rem_q    <= rem_d;
      rd_ptr_q <= rd_ptr_d;
      valid_q  <= re_o;
      last_q   <= re_o && (rem_q == CNT_W'(1));
    end
  end

endmodule

// ===== hw/rtl/mebr_checker.sv =====
// port checker for the midi event beat release buffer, bound to the top level
// uses mebr_pkg
`timescale 1ns / 1ps

module mebr_checker import mebr_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    result_valid_o,
  input result_t result_o
);

  // a burst runs without gaps until its last beat
  a_burst_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |=> result_valid_o)
    else $error("gap inside a release burst");

  // a beat flagged last is never directly followed by another beat
  a_burst_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |=> !result_valid_o)
    else $error("beat directly after last beat");

  // no beat at the sample where reset has just been released
  a_no_beat_from_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !result_valid_o)
    else $error("beat right after reset");

  a_beat_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !$isunknown(result_o))
    else $error("unknown beat payload");

endmodule

bind midi_event_beat_release_buffer mebr_checker u_mebr_checker (.*);

// ===== tb/sv/tb.sv =====
// testbench for the midi event beat release buffer: directed and random beats,
// released events checked against a behavioral predictor of the store and countdown
// depends on mebr_pkg and midi_event_beat_release_buffer
`timescale 1ns / 1ps

module tb;
  import mebr_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 80;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  item_t               item_drv = '0;
  logic                result_valid_o;
  result_t             result_o;
  logic                cfg_we_i = 1'b0;
  logic [PERIOD_W-1:0] cfg_data_i = '0;

  midi_event_beat_release_buffer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_drv),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted block state
  logic [EVENT_W-1:0]  evt_store [EVENT_DEPTH];
  int unsigned         evt_count;
  logic [PERIOD_W-1:0] countdown;
  logic [PERIOD_W-1:0] period_reg;
  logic [7:0]          prev_transport;
  logic                is_playing;

  result_t     released_events [$];
  item_t       pending_items [$];
  logic [7:0]  cur_ts = 8'h00;
  bit          beat_taken = 1'b0;
  int unsigned fail_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;

  function automatic void predict_beat(item_t it);
    logic [7:0]          ts;
    logic [PERIOD_W-1:0] per;
    result_t             r;
    if (it.action == ACT_EVENT) begin
      if (evt_count < EVENT_DEPTH) begin
        evt_store[evt_count] = {it.status_byte, it.data_one, it.data_two};
        evt_count++;
      end
    end else begin
      ts = it.transport_state & TRANSPORT_MASK;
      if (ts != prev_transport) begin
        is_playing = ts[1];
        if (ts[1]) countdown = '0;
        prev_transport = ts;
      end
      if (is_playing) begin
        if (countdown == '0) begin
          for (int i = 0; i < int'(evt_count); i++) begin
            r.out_status   = evt_store[i][23:16];
            r.out_data_one = evt_store[i][15:8];
            r.out_data_two = evt_store[i][7:0];
            r.last         = (i == int'(evt_count) - 1);
            released_events.push_back(r);
          end
          evt_count = 0;
          per = (period_reg < PERIOD_FLOOR) ? PERIOD_FLOOR : period_reg;
          countdown = per - 1'b1;
        end else begin
          countdown = countdown - 1'b1;
        end
      end
    end
  endfunction

  function automatic void cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
    end
  endfunction

  // monitor and predictor
  always @(posedge clk_i) begin : monitor_proc
    result_t exp_r;
    if (!rst_ni) begin
      evt_count      = 0;
      countdown      = '0;
      period_reg     = PERIOD_RESET;
      prev_transport = 8'h00;
      is_playing     = 1'b0;
      beat_taken     = 1'b0;
    end else begin
      if (result_valid_o) begin
        if (released_events.size() == 0) begin
          fail_count++;
          $error("result beat with no event expected");
        end else begin
          exp_r = released_events.pop_front();
          cmp_field("out_status", exp_r.out_status, result_o.out_status);
          cmp_field("out_data_one", exp_r.out_data_one, result_o.out_data_one);
          cmp_field("out_data_two", exp_r.out_data_two, result_o.out_data_two);
          cmp_field("last", 8'(exp_r.last), 8'(result_o.last));
        end
      end
      if (cfg_we_i) period_reg = cfg_data_i;
      beat_taken = start && !busy;
      if (beat_taken) predict_beat(item_drv);
    end
  end

  // driver: bursts of beats with random gaps
  always @(negedge clk_i) begin : driver_proc
    logic  nxt_start;
    item_t nxt_item;
    if (rst_ni) begin
      nxt_start = start;
      nxt_item  = item_drv;
      if (beat_taken) nxt_start = 1'b0;
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          nxt_item  = pending_items.pop_front();
          nxt_start = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      start    <= nxt_start;
      item_drv <= nxt_item;
    end
  end

  task automatic push_event(logic [7:0] s, logic [7:0] d1, logic [7:0] d2);
    item_t it;
    it.action          = ACT_EVENT;
    it.status_byte     = s;
    it.data_one        = d1;
    it.data_two        = d2;
    it.transport_state = 8'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic push_tick(logic [7:0] ts);
    item_t it;
    it.action          = ACT_TICK;
    it.status_byte     = 8'($urandom);
    it.data_one        = 8'($urandom);
    it.data_two        = 8'($urandom);
    it.transport_state = ts;
    cur_ts = ts;
    pending_items.push_back(it);
  endtask

  // a transport value that differs from the current one in the masked bits
  function automatic logic [7:0] fresh_transport(bit play);
    logic [7:0] ts;
    do begin
      ts    = 8'($urandom);
      ts[1] = play;
    end while ((ts & TRANSPORT_MASK) == (cur_ts & TRANSPORT_MASK));
    return ts;
  endfunction

  task automatic gen_random(int n, int tick_pct, int change_pct);
    push_tick(fresh_transport(1'b1));
    for (int k = 1; k < n; k++) begin
      if ($urandom_range(1, 100) <= change_pct)
        push_tick(fresh_transport($urandom_range(0, 3) != 0));
      else if ($urandom_range(1, 100) <= tick_pct)
        push_tick({cur_ts[7:1], 1'($urandom)});
      else
        push_event(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // overfill the store, then release
  task automatic gen_flood();
    repeat (70) push_event(8'($urandom), 8'($urandom), 8'($urandom));
    push_tick(fresh_transport(1'b1));
    repeat (5) push_tick(cur_ts);
  endtask

  task automatic settle();
    while (pending_items.size() != 0 || start || released_events.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_period(logic [PERIOD_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed beats at the reset period
    push_tick(8'h00);
    push_event(8'h00, 8'h00, 8'h00);
    push_event(8'hFF, 8'hFF, 8'hFF);
    push_event(8'h90, 8'h3C, 8'h7F);
    push_tick(8'h01);
    push_tick(8'h02);
    push_tick(8'h03);
    push_tick(8'h02);
    push_event(8'h80, 8'h40, 8'h00);
    push_tick(8'hFE);
    push_tick(8'hFF);
    push_tick(8'h00);
    push_event(8'hA5, 8'h5A, 8'hC3);
    push_tick(8'h04);
    push_tick(8'h06);
    push_tick(8'h02);
    push_event(8'h7F, 8'h80, 8'h01);
    push_event(8'h01, 8'h02, 8'h04);
    push_tick(8'h00);
    gen_random(20, 60, 10);
    settle();

    write_period('0);
    gen_random(80, 80, 3);
    gen_flood();
    settle();

    write_period(PERIOD_W'(65));
    gen_random(90, 85, 0);
    settle();

    write_period('1);
    gen_random(30, 60, 10);
    settle();

    write_period(PERIOD_W'(64));
    gen_random(60, 75, 5);
    settle();

    write_period(PERIOD_W'(63));
    gen_random(30, 60, 10);
    settle();

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mebr_pkg.sv
hw/rtl/mebr_ram.sv
hw/rtl/mebr_front.sv
hw/rtl/mebr_queue.sv
hw/rtl/mebr_back.sv
hw/rtl/midi_event_beat_release_buffer.sv
hw/rtl/mebr_checker.sv
tb/sv/tb.sv
